// ===== rtl/core/rvd_pkg.sv =====
// Shared types and constants for the RV32I instruction decoder.
// Opcode and funct encodings, format and operation codes, decode result struct.
// No dependencies.
package rvd_pkg;

  // Major opcodes (bits 6:0)
  localparam logic [6:0] OPC_R     = 7'b0110011;
  localparam logic [6:0] OPC_IALU  = 7'b0010011;
  localparam logic [6:0] OPC_LOAD  = 7'b0000011;
  localparam logic [6:0] OPC_JALR  = 7'b1100111;
  localparam logic [6:0] OPC_STORE = 7'b0100011;
  localparam logic [6:0] OPC_BR    = 7'b1100011;
  localparam logic [6:0] OPC_AUIPC = 7'b0010111;
  localparam logic [6:0] OPC_LUI   = 7'b0110111;
  localparam logic [6:0] OPC_JAL   = 7'b1101111;

  // funct7 values
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // funct3 values, ALU group
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // funct3 values, loads and stores
  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;

  // funct3 values, branches and jalr
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;
  localparam logic [2:0] F3_JALR = 3'd0;

  // Address tag width
  localparam int unsigned TagW = 12;

  typedef enum logic [3:0] {
    FMT_R      = 4'd0,
    FMT_I_ALU  = 4'd1,
    FMT_I_SHFT = 4'd2,
    FMT_I_LOAD = 4'd3,
    FMT_JALR   = 4'd4,
    FMT_S      = 4'd5,
    FMT_B      = 4'd6,
    FMT_U      = 4'd7,
    FMT_J      = 4'd8
  } fmt_e;

  typedef enum logic [5:0] {
    OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_SLL, OP_SRL, OP_SRA, OP_SLT, OP_SLTU,
    OP_SLLI, OP_SRLI, OP_SRAI, OP_ADDI, OP_ANDI, OP_ORI, OP_XORI, OP_SLTI, OP_SLTIU,
    OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_JALR, OP_SB, OP_SH, OP_SW,
    OP_BEQ, OP_BGE, OP_BGEU, OP_BLT, OP_BLTU, OP_BNE, OP_AUIPC, OP_LUI, OP_JAL
  } op_e;

  typedef struct packed {
    fmt_e               fmt;
    op_e                op;
    logic [4:0]         rd;
    logic [4:0]         rs1;
    logic [4:0]         rs2;
    logic signed [31:0] imm;
    logic [TagW-1:0]    tag;
    logic               illegal;
  } rvd_result_t;

endpackage

// ===== rtl/core/rvd_decode.sv =====
// Combinational RV32I decode: format, operation, register fields, immediate.
// Depends on rvd_pkg.
module rvd_decode (
  input  logic [31:0]         addr_i,
  input  logic [31:0]         word_i,
  output rvd_pkg::rvd_result_t result_o
);
  import rvd_pkg::*;

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_u;
  logic [31:0] imm_j;
  logic [31:0] imm_sh;
  fmt_e        fmt;
  op_e         op;
  logic [31:0] imm;
  logic        known;

  assign opc = word_i[6:0];
  assign f3  = word_i[14:12];
  assign f7  = word_i[31:25];

  // Immediate forms
  assign imm_i  = {{20{word_i[31]}}, word_i[31:20]};
  assign imm_s  = {{20{word_i[31]}}, word_i[31:25], word_i[11:7]};
  assign imm_b  = {{19{word_i[31]}}, word_i[31], word_i[7], word_i[30:25],
                   word_i[11:8], 1'b0};
  assign imm_u  = {word_i[31:12], 12'd0};
  assign imm_j  = {{11{word_i[31]}}, word_i[31], word_i[19:12], word_i[20],
                   word_i[30:21], 1'b0};
  assign imm_sh = {27'd0, word_i[24:20]};

  // Opcode and funct decode
  always_comb begin
    fmt   = FMT_R;
    op    = OP_ADD;
    imm   = 32'd0;
    known = 1'b0;
    unique case (opc)
      OPC_R: begin
        known = 1'b1;
        unique case ({f3, f7})
          {F3_ADD,  F7_BASE}: op = OP_ADD;
          {F3_ADD,  F7_ALT}:  op = OP_SUB;
          {F3_AND,  F7_BASE}: op = OP_AND;
          {F3_OR,   F7_BASE}: op = OP_OR;
          {F3_XOR,  F7_BASE}: op = OP_XOR;
          {F3_SLL,  F7_BASE}: op = OP_SLL;
          {F3_SR,   F7_BASE}: op = OP_SRL;
          {F3_SR,   F7_ALT}:  op = OP_SRA;
          {F3_SLT,  F7_BASE}: op = OP_SLT;
          {F3_SLTU, F7_BASE}: op = OP_SLTU;
          default:            known = 1'b0;
        endcase
      end
      OPC_IALU: begin
        known = 1'b1;
        if (f3 == F3_SLL || f3 == F3_SR) begin
          fmt = FMT_I_SHFT;
          imm = imm_sh;
          unique case ({f3, f7})
            {F3_SLL, F7_BASE}: op = OP_SLLI;
            {F3_SR,  F7_BASE}: op = OP_SRLI;
            {F3_SR,  F7_ALT}:  op = OP_SRAI;
            default:           known = 1'b0;
          endcase
        end else begin
          fmt = FMT_I_ALU;
          imm = imm_i;
          unique case (f3)
            F3_ADD:  op = OP_ADDI;
            F3_AND:  op = OP_ANDI;
            F3_OR:   op = OP_ORI;
            F3_XOR:  op = OP_XORI;
            F3_SLT:  op = OP_SLTI;
            F3_SLTU: op = OP_SLTIU;
            default: known = 1'b0;
          endcase
        end
      end
      OPC_LOAD: begin
        fmt   = FMT_I_LOAD;
        imm   = imm_i;
        known = 1'b1;
        unique case (f3)
          F3_B:    op = OP_LB;
          F3_BU:   op = OP_LBU;
          F3_H:    op = OP_LH;
          F3_HU:   op = OP_LHU;
          F3_W:    op = OP_LW;
          default: known = 1'b0;
        endcase
      end
      OPC_JALR: begin
        fmt   = FMT_JALR;
        imm   = imm_i;
        known = (f3 == F3_JALR);
        op    = known ? OP_JALR : OP_ADD;
      end
      OPC_STORE: begin
        fmt   = FMT_S;
        imm   = imm_s;
        known = 1'b1;
        unique case (f3)
          F3_B:    op = OP_SB;
          F3_H:    op = OP_SH;
          F3_W:    op = OP_SW;
          default: known = 1'b0;
        endcase
      end
      OPC_BR: begin
        fmt   = FMT_B;
        imm   = imm_b;
        known = 1'b1;
        unique case (f3)
          F3_BEQ:  op = OP_BEQ;
          F3_BGE:  op = OP_BGE;
          F3_BGEU: op = OP_BGEU;
          F3_BLT:  op = OP_BLT;
          F3_BLTU: op = OP_BLTU;
          F3_BNE:  op = OP_BNE;
          default: known = 1'b0;
        endcase
      end
      OPC_AUIPC: begin
        fmt   = FMT_U;
        imm   = imm_u;
        op    = OP_AUIPC;
        known = 1'b1;
      end
      OPC_LUI: begin
        fmt   = FMT_U;
        imm   = imm_u;
        op    = OP_LUI;
        known = 1'b1;
      end
      OPC_JAL: begin
        fmt   = FMT_J;
        imm   = imm_j;
        op    = OP_JAL;
        known = 1'b1;
      end
      default: ;
    endcase
  end

  // Pack the result
  always_comb begin
    result_o.fmt     = fmt;
    result_o.op      = known ? op : OP_ADD;
    result_o.rd      = word_i[11:7];
    result_o.rs1     = word_i[19:15];
    result_o.rs2     = word_i[24:20];
    result_o.imm     = imm;
    result_o.tag     = addr_i[TagW-1:0];
    result_o.illegal = !known;
  end

endmodule

// ===== rtl/core/rvd_result_reg.sv =====
// Output register stage holding one decoded result until the sink takes it.
// Depends on rvd_pkg.
module rvd_result_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  rvd_pkg::rvd_result_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output rvd_pkg::rvd_result_t data_o
);
  import rvd_pkg::*;

  logic        valid_q;
  rvd_result_t data_q;

  // Can load when empty or when the held result leaves this cycle
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

// ===== rtl/core/rv32i_instruction_decoder_top.sv =====
// RV32I instruction decoder top level: input register, decode logic, result register.
// Depends on rvd_pkg, rvd_decode and rvd_result_reg.
//
// Usage:
//   Slave stream s_axis carries one instruction per transaction: tdata holds the
//   fetch address and the raw instruction word. Master stream m_axis returns one
//   decoded result per instruction, in order: format class, operation number,
//   register indexes, immediate and the low 12 address bits in tdata, and the
//   illegal-encoding flag in tuser.
//   The accepting edge loads the input register; the decoded result then moves into
//   the result register once that register can take it, and m_axis presents it.
//   Throughput is one instruction per cycle while m_axis_tready is high.
//   Reset clears both stage valid flags; no result is presented until an
//   instruction is taken. When the sink stalls, the result register holds its
//   transaction, the input register fills behind it, and s_axis_tready drops
//   once both are occupied; nothing is dropped or repeated.
module rv32i_instruction_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: [31:0] instr_address, [63:32] instr_word
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: [3:0] format_class, [9:4] op_kind, [14:10] dest_reg, [19:15] src1_reg,
  //        [24:20] src2_reg, [56:25] imm_value, [68:57] addr_tag, [71:69] zero
  output logic [71:0] m_axis_tdata,
  // tuser: [0] illegal
  output logic        m_axis_tuser
);
  import rvd_pkg::*;

  logic        in_valid_q;
  logic [31:0] in_addr_q;
  logic [31:0] in_word_q;
  logic        res_ready;
  rvd_result_t dec_result;
  rvd_result_t out_result;

  // Input register accepts when empty or when its content moves on
  assign s_axis_tready = !in_valid_q || res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_addr_q <= s_axis_tdata[31:0];
      in_word_q <= s_axis_tdata[63:32];
    end
  end

  // Decode
  rvd_decode u_decode (
    .addr_i   (in_addr_q),
    .word_i   (in_word_q),
    .result_o (dec_result)
  );

  // Result register
  rvd_result_reg u_result_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .ready_o (res_ready),
    .data_i  (dec_result),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_result)
  );

  // Output packing
  assign m_axis_tdata = {3'b000, out_result.tag, out_result.imm, out_result.rs2,
                         out_result.rs1, out_result.rd, out_result.op, out_result.fmt};
  assign m_axis_tuser = out_result.illegal;

`ifndef SYNTHESIS
  // An illegal encoding always reports operation zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> out_result.op == OP_ADD)
    else $error("illegal result with nonzero op_kind");

  // Format class stays in its defined range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_result.fmt <= FMT_J)
    else $error("format_class out of range");

  // R format (and unknown opcodes) carry a zero immediate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_result.fmt == FMT_R |-> out_result.imm == 32'sd0)
    else $error("R format with nonzero immediate");

  // A pending instruction reaches an empty result register in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !m_axis_tvalid |=> m_axis_tvalid)
    else $error("decoded instruction not forwarded");
`endif

endmodule

// ===== tb/sv/tb_rv32i_instruction_decoder_top.sv =====
// Self-checking testbench for rv32i_instruction_decoder_top: directed corner encodings,
// then well-formed and noisy random instructions, checked against a local decoder model.
// Depends on rvd_pkg and the decoder RTL.
module tb_rv32i_instruction_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rvd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1025;
  localparam int DRAIN_CYCLES = 4;

  // Which funct fields an operation pins down
  localparam logic [1:0] PIN_F3_F7 = 2'b11;
  localparam logic [1:0] PIN_F3    = 2'b10;
  localparam logic [1:0] PIN_NONE  = 2'b00;

  // One directed row; typed rows carry fmt/op/imm/illegal written out by hand
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] word;
    logic        typed;
    fmt_e        fmt;
    op_e         op;
    logic [31:0] imm;
    logic        illegal;
  } corner_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;

  rvd_result_t pending_decodes [$];
  corner_row_t corner_rows [$];
  rvd_result_t head_decode;
  int          err_count = 0;
  int          stall_cycles = 0;
  int          send_idle_pct = 25;
  int          recv_idle_pct = 85;

  rv32i_instruction_decoder_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Decode one instruction word the way the block should
  function automatic rvd_result_t decode_instr(input logic [31:0] addr, input logic [31:0] w);
    rvd_result_t r;
    logic [2:0]  f3;
    logic [6:0]  f7;
    int          code;
    f3 = w[14:12];
    f7 = w[31:25];
    code = -1;
    r.fmt = FMT_R;
    r.imm = '0;
    case (w[6:0])
      OPC_R: begin
        case ({f3, f7})
          {F3_ADD, F7_BASE}:  code = OP_ADD;
          {F3_ADD, F7_ALT}:   code = OP_SUB;
          {F3_AND, F7_BASE}:  code = OP_AND;
          {F3_OR, F7_BASE}:   code = OP_OR;
          {F3_XOR, F7_BASE}:  code = OP_XOR;
          {F3_SLL, F7_BASE}:  code = OP_SLL;
          {F3_SR, F7_BASE}:   code = OP_SRL;
          {F3_SR, F7_ALT}:    code = OP_SRA;
          {F3_SLT, F7_BASE}:  code = OP_SLT;
          {F3_SLTU, F7_BASE}: code = OP_SLTU;
          default: ;
        endcase
      end
      OPC_IALU: begin
        if (f3 == F3_SLL || f3 == F3_SR) begin
          // shift amount is zero-extended, funct7 must be valid
          r.fmt = FMT_I_SHFT;
          r.imm = {27'b0, w[24:20]};
          case ({f3, f7})
            {F3_SLL, F7_BASE}: code = OP_SLLI;
            {F3_SR, F7_BASE}:  code = OP_SRLI;
            {F3_SR, F7_ALT}:   code = OP_SRAI;
            default: ;
          endcase
        end else begin
          r.fmt = FMT_I_ALU;
          r.imm = {{20{w[31]}}, w[31:20]};
          case (f3)
            F3_ADD:  code = OP_ADDI;
            F3_AND:  code = OP_ANDI;
            F3_OR:   code = OP_ORI;
            F3_XOR:  code = OP_XORI;
            F3_SLT:  code = OP_SLTI;
            F3_SLTU: code = OP_SLTIU;
            default: ;
          endcase
        end
      end
      OPC_LOAD: begin
        r.fmt = FMT_I_LOAD;
        r.imm = {{20{w[31]}}, w[31:20]};
        case (f3)
          F3_B:  code = OP_LB;
          F3_BU: code = OP_LBU;
          F3_H:  code = OP_LH;
          F3_HU: code = OP_LHU;
          F3_W:  code = OP_LW;
          default: ;
        endcase
      end
      OPC_JALR: begin
        r.fmt = FMT_JALR;
        r.imm = {{20{w[31]}}, w[31:20]};
        if (f3 == F3_JALR) code = OP_JALR;
      end
      OPC_STORE: begin
        r.fmt = FMT_S;
        r.imm = {{20{w[31]}}, w[31:25], w[11:7]};
        case (f3)
          F3_B: code = OP_SB;
          F3_H: code = OP_SH;
          F3_W: code = OP_SW;
          default: ;
        endcase
      end
      OPC_BR: begin
        r.fmt = FMT_B;
        r.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          F3_BEQ:  code = OP_BEQ;
          F3_BGE:  code = OP_BGE;
          F3_BGEU: code = OP_BGEU;
          F3_BLT:  code = OP_BLT;
          F3_BLTU: code = OP_BLTU;
          F3_BNE:  code = OP_BNE;
          default: ;
        endcase
      end
      OPC_AUIPC: begin
        r.fmt = FMT_U;
        r.imm = {w[31:12], 12'b0};
        code = OP_AUIPC;
      end
      OPC_LUI: begin
        r.fmt = FMT_U;
        r.imm = {w[31:12], 12'b0};
        code = OP_LUI;
      end
      OPC_JAL: begin
        r.fmt = FMT_J;
        r.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
        code = OP_JAL;
      end
      default: ;
    endcase
    r.op = (code < 0) ? OP_ADD : op_e'(code);
    r.illegal = (code < 0);
    r.rd = w[11:7];
    r.rs1 = w[19:15];
    r.rs2 = w[24:20];
    r.tag = addr[TagW-1:0];
    return r;
  endfunction

  // Force opcode and funct fields of an operation onto random fill
  function automatic logic [31:0] encode_op(input op_e op, input logic [31:0] fill);
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [1:0]  pin;
    logic [31:0] w;
    case (op)
      OP_ADD:   {opc, f3, f7, pin} = {OPC_R, F3_ADD, F7_BASE, PIN_F3_F7};
      OP_SUB:   {opc, f3, f7, pin} = {OPC_R, F3_ADD, F7_ALT, PIN_F3_F7};
      OP_AND:   {opc, f3, f7, pin} = {OPC_R, F3_AND, F7_BASE, PIN_F3_F7};
      OP_OR:    {opc, f3, f7, pin} = {OPC_R, F3_OR, F7_BASE, PIN_F3_F7};
      OP_XOR:   {opc, f3, f7, pin} = {OPC_R, F3_XOR, F7_BASE, PIN_F3_F7};
      OP_SLL:   {opc, f3, f7, pin} = {OPC_R, F3_SLL, F7_BASE, PIN_F3_F7};
      OP_SRL:   {opc, f3, f7, pin} = {OPC_R, F3_SR, F7_BASE, PIN_F3_F7};
      OP_SRA:   {opc, f3, f7, pin} = {OPC_R, F3_SR, F7_ALT, PIN_F3_F7};
      OP_SLT:   {opc, f3, f7, pin} = {OPC_R, F3_SLT, F7_BASE, PIN_F3_F7};
      OP_SLTU:  {opc, f3, f7, pin} = {OPC_R, F3_SLTU, F7_BASE, PIN_F3_F7};
      OP_SLLI:  {opc, f3, f7, pin} = {OPC_IALU, F3_SLL, F7_BASE, PIN_F3_F7};
      OP_SRLI:  {opc, f3, f7, pin} = {OPC_IALU, F3_SR, F7_BASE, PIN_F3_F7};
      OP_SRAI:  {opc, f3, f7, pin} = {OPC_IALU, F3_SR, F7_ALT, PIN_F3_F7};
      OP_ADDI:  {opc, f3, f7, pin} = {OPC_IALU, F3_ADD, F7_BASE, PIN_F3};
      OP_ANDI:  {opc, f3, f7, pin} = {OPC_IALU, F3_AND, F7_BASE, PIN_F3};
      OP_ORI:   {opc, f3, f7, pin} = {OPC_IALU, F3_OR, F7_BASE, PIN_F3};
      OP_XORI:  {opc, f3, f7, pin} = {OPC_IALU, F3_XOR, F7_BASE, PIN_F3};
      OP_SLTI:  {opc, f3, f7, pin} = {OPC_IALU, F3_SLT, F7_BASE, PIN_F3};
      OP_SLTIU: {opc, f3, f7, pin} = {OPC_IALU, F3_SLTU, F7_BASE, PIN_F3};
      OP_LB:    {opc, f3, f7, pin} = {OPC_LOAD, F3_B, F7_BASE, PIN_F3};
      OP_LBU:   {opc, f3, f7, pin} = {OPC_LOAD, F3_BU, F7_BASE, PIN_F3};
      OP_LH:    {opc, f3, f7, pin} = {OPC_LOAD, F3_H, F7_BASE, PIN_F3};
      OP_LHU:   {opc, f3, f7, pin} = {OPC_LOAD, F3_HU, F7_BASE, PIN_F3};
      OP_LW:    {opc, f3, f7, pin} = {OPC_LOAD, F3_W, F7_BASE, PIN_F3};
      OP_JALR:  {opc, f3, f7, pin} = {OPC_JALR, F3_JALR, F7_BASE, PIN_F3};
      OP_SB:    {opc, f3, f7, pin} = {OPC_STORE, F3_B, F7_BASE, PIN_F3};
      OP_SH:    {opc, f3, f7, pin} = {OPC_STORE, F3_H, F7_BASE, PIN_F3};
      OP_SW:    {opc, f3, f7, pin} = {OPC_STORE, F3_W, F7_BASE, PIN_F3};
      OP_BEQ:   {opc, f3, f7, pin} = {OPC_BR, F3_BEQ, F7_BASE, PIN_F3};
      OP_BGE:   {opc, f3, f7, pin} = {OPC_BR, F3_BGE, F7_BASE, PIN_F3};
      OP_BGEU:  {opc, f3, f7, pin} = {OPC_BR, F3_BGEU, F7_BASE, PIN_F3};
      OP_BLT:   {opc, f3, f7, pin} = {OPC_BR, F3_BLT, F7_BASE, PIN_F3};
      OP_BLTU:  {opc, f3, f7, pin} = {OPC_BR, F3_BLTU, F7_BASE, PIN_F3};
      OP_BNE:   {opc, f3, f7, pin} = {OPC_BR, F3_BNE, F7_BASE, PIN_F3};
      OP_AUIPC: {opc, f3, f7, pin} = {OPC_AUIPC, F3_ADD, F7_BASE, PIN_NONE};
      OP_LUI:   {opc, f3, f7, pin} = {OPC_LUI, F3_ADD, F7_BASE, PIN_NONE};
      default:  {opc, f3, f7, pin} = {OPC_JAL, F3_ADD, F7_BASE, PIN_NONE};
    endcase
    w = fill;
    w[6:0] = opc;
    if (pin[1]) w[14:12] = f3;
    if (pin[0]) w[31:25] = f7;
    return w;
  endfunction

  // Present one instruction with random gaps; queue its decode on acceptance
  task automatic issue_instr(input logic [31:0] addr, input logic [31:0] word,
                             input rvd_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {word, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_decodes.push_back(want);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Sink backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker and progress counter
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_decodes.size() == 0) begin
          err_count++;
          $display("%0t ns: unexpected result, expected none, actual %h/%b", $time,
                   m_axis_tdata, m_axis_tuser);
        end else begin
          head_decode = pending_decodes.pop_front();
          check_field("format_class", 32'(head_decode.fmt), 32'(m_axis_tdata[3:0]));
          check_field("op_kind", 32'(head_decode.op), 32'(m_axis_tdata[9:4]));
          check_field("dest_reg", 32'(head_decode.rd), 32'(m_axis_tdata[14:10]));
          check_field("src1_reg", 32'(head_decode.rs1), 32'(m_axis_tdata[19:15]));
          check_field("src2_reg", 32'(head_decode.rs2), 32'(m_axis_tdata[24:20]));
          check_field("imm_value", head_decode.imm, m_axis_tdata[56:25]);
          check_field("addr_tag", 32'(head_decode.tag), 32'(m_axis_tdata[68:57]));
          check_field("tdata_pad", 32'(0), 32'(m_axis_tdata[71:69]));
          check_field("illegal", 32'(head_decode.illegal), 32'(m_axis_tuser));
        end
      end
    end
  end

  // Watchdog on lack of progress
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus
  initial begin
    rvd_result_t want;
    logic [31:0] addr;
    logic [31:0] word;
    int          pick;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner encodings: extremes of every immediate form and each illegal path
    corner_rows.push_back({32'h0000_0000, 32'h0000_0000, 1'b1, FMT_R, OP_ADD, 32'h0, 1'b1});
    corner_rows.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, FMT_R, OP_ADD, 32'h0, 1'b1});
    corner_rows.push_back({32'h0000_0FFC, 32'h0000_000F, 1'b1, FMT_R, OP_ADD, 32'h0, 1'b1});
    corner_rows.push_back({32'h0000_1000, 32'h0000_0033, 1'b1, FMT_R, OP_ADD, 32'h0, 1'b0});
    corner_rows.push_back({32'h8000_0000, 32'h41FF_8FB3, 1'b0, FMT_R, OP_ADD, 32'h0, 1'b0});
    corner_rows.push_back({32'h1234_5678, 32'h4030_D2B3, 1'b0, FMT_R, OP_ADD, 32'h0, 1'b0});
    // R-type with an undefined funct7
    corner_rows.push_back({32'h0000_0004, 32'hFE00_0033, 1'b1, FMT_R, OP_ADD, 32'h0, 1'b1});
    corner_rows.push_back({32'h0000_0008, 32'h7FF0_0013, 1'b1, FMT_I_ALU, OP_ADDI,
                           32'h0000_07FF, 1'b0});
    corner_rows.push_back({32'h0000_000C, 32'h8000_0013, 1'b1, FMT_I_ALU, OP_ADDI,
                           32'hFFFF_F800, 1'b0});
    corner_rows.push_back({32'h0000_0010, 32'h01F0_1013, 1'b1, FMT_I_SHFT, OP_SLLI,
                           32'h0000_001F, 1'b0});
    corner_rows.push_back({32'h0000_0014, 32'h41F0_5013, 1'b1, FMT_I_SHFT, OP_SRAI,
                           32'h0000_001F, 1'b0});
    // shift-immediates with a bad funct7 keep their format and shift amount
    corner_rows.push_back({32'h0000_0018, 32'h41F0_1013, 1'b1, FMT_I_SHFT, OP_ADD,
                           32'h0000_001F, 1'b1});
    corner_rows.push_back({32'h0000_001C, 32'h0200_5013, 1'b1, FMT_I_SHFT, OP_ADD,
                           32'h0, 1'b1});
    corner_rows.push_back({32'h0000_0020, 32'hFFF0_2003, 1'b1, FMT_I_LOAD, OP_LW,
                           32'hFFFF_FFFF, 1'b0});
    corner_rows.push_back({32'h0000_0024, 32'h0000_3003, 1'b1, FMT_I_LOAD, OP_ADD,
                           32'h0, 1'b1});
    // jalr immediate comes from bits 31:20; nonzero funct3 is illegal
    corner_rows.push_back({32'h0000_0028, 32'hFFF0_0067, 1'b1, FMT_JALR, OP_JALR,
                           32'hFFFF_FFFF, 1'b0});
    corner_rows.push_back({32'h0000_002C, 32'h7FF0_1067, 1'b1, FMT_JALR, OP_ADD,
                           32'h0000_07FF, 1'b1});
    corner_rows.push_back({32'h0000_0030, 32'h8000_2023, 1'b1, FMT_S, OP_SW,
                           32'hFFFF_F800, 1'b0});
    corner_rows.push_back({32'h0000_0034, 32'h0000_3023, 1'b1, FMT_S, OP_ADD, 32'h0, 1'b1});
    corner_rows.push_back({32'h0000_0038, 32'h7E00_0FE3, 1'b1, FMT_B, OP_BEQ,
                           32'h0000_0FFE, 1'b0});
    corner_rows.push_back({32'h0000_003C, 32'h8000_4063, 1'b1, FMT_B, OP_BLT,
                           32'hFFFF_F000, 1'b0});
    corner_rows.push_back({32'h0000_0040, 32'h0000_2063, 1'b1, FMT_B, OP_ADD, 32'h0, 1'b1});
    corner_rows.push_back({32'h0000_0044, 32'hFFFF_F037, 1'b1, FMT_U, OP_LUI,
                           32'hFFFF_F000, 1'b0});
    corner_rows.push_back({32'h0000_0048, 32'h0000_1017, 1'b1, FMT_U, OP_AUIPC,
                           32'h0000_1000, 1'b0});
    corner_rows.push_back({32'h0000_004C, 32'h8000_006F, 1'b1, FMT_J, OP_JAL,
                           32'hFFF0_0000, 1'b0});
    corner_rows.push_back({32'h0000_0050, 32'h7FFF_F06F, 1'b1, FMT_J, OP_JAL,
                           32'h000F_FFFE, 1'b0});

    foreach (corner_rows[i]) begin
      if (corner_rows[i].typed) begin
        want.fmt = corner_rows[i].fmt;
        want.op = corner_rows[i].op;
        want.rd = corner_rows[i].word[11:7];
        want.rs1 = corner_rows[i].word[19:15];
        want.rs2 = corner_rows[i].word[24:20];
        want.imm = corner_rows[i].imm;
        want.tag = corner_rows[i].addr[TagW-1:0];
        want.illegal = corner_rows[i].illegal;
      end else begin
        want = decode_instr(corner_rows[i].addr, corner_rows[i].word);
      end
      issue_instr(corner_rows[i].addr, corner_rows[i].word, want);
    end

    // Random part: mostly well-formed, some known opcodes with random funct, some noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 85;
        recv_idle_pct = 25;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      addr = $urandom;
      word = $urandom;
      pick = $urandom_range(99);
      if (i <= int'(OP_JAL)) begin
        // first sweep hits every operation once
        word = encode_op(op_e'(i), word);
      end else if (pick < 75) begin
        word = encode_op(op_e'($urandom_range(int'(OP_JAL))), word);
      end else if (pick < 88) begin
        case ($urandom_range(8))
          0: word[6:0] = OPC_R;
          1: word[6:0] = OPC_IALU;
          2: word[6:0] = OPC_LOAD;
          3: word[6:0] = OPC_JALR;
          4: word[6:0] = OPC_STORE;
          5: word[6:0] = OPC_BR;
          6: word[6:0] = OPC_AUIPC;
          7: word[6:0] = OPC_LUI;
          default: word[6:0] = OPC_JAL;
        endcase
      end
      issue_instr(addr, word, decode_instr(addr, word));
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then a short quiet window to catch extra results
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rvd_pkg.sv
rtl/core/rvd_decode.sv
rtl/core/rvd_result_reg.sv
rtl/core/rv32i_instruction_decoder_top.sv
tb/sv/tb_rv32i_instruction_decoder_top.sv
